### hdl/bss_pkg.sv
package bss_pkg;

	// element width and default set capacity
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned MAX_COUNT_DEF = 16;

	// input transfer payload
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last_item;
	} in_item_t;

	// output transfer payload
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     last_result;
	} out_item_t;

	// compare/exchange unit result
	typedef struct packed {
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic              swap;
	} cmp_res_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_COLLECT,
		S_LOAD,
		S_FIRST,
		S_READ,
		S_CMP,
		S_TAIL,
		S_OUT_RD,
		S_OUT_LD
	} state_t;

endpackage

### hdl/bubble_sort_ascending_top.sv
// Collects signed 32-bit values one transfer at a time into an on-chip buffer of
// MAX_COUNT entries; a transfer marked last_item, or the one that fills the buffer,
// closes the set. The set is then sorted ascending with bubble passes and streamed
// out smallest first, last_result on the final value. in_ready is high only while
// a set is being collected, one value per cycle. Sorting a set of n values (n >= 2)
// takes (n-1) passes; every pass walks the buffer through the single RAM read
// port, one registered read and one compare/exchange per element, with the larger
// value carried along in a register. Each output value is read, then loaded into
// the output register once it is free. A set of one value skips the sort.
module bubble_sort_ascending_top #(
	parameter int unsigned MAX_COUNT = bss_pkg::MAX_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bss_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bss_pkg::out_item_t out_data
);

	localparam int unsigned AW = $clog2(MAX_COUNT);
	localparam int unsigned CW = $clog2(MAX_COUNT + 1);

	bss_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [AW-1:0] pass_q, pass_d;
	logic [bss_pkg::DATA_W-1:0] carry_q, carry_d;

	logic                       we;
	logic [AW-1:0]              waddr;
	logic [bss_pkg::DATA_W-1:0] wdata;
	logic [AW-1:0]              raddr;
	logic [bss_pkg::DATA_W-1:0] rdata;

	bss_pkg::cmp_res_t cmp_res;

	logic              in_xfer;
	logic              out_load;
	logic              out_valid_q;
	bss_pkg::out_item_t out_q;

	logic [CW-1:0] count_inc;
	logic [CW-1:0] n_minus1;
	logic [CW-1:0] n_minus2;
	logic          idx_at_end;

	// element buffer
	bss_ram #(
		.WIDTH(bss_pkg::DATA_W),
		.DEPTH(MAX_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// shared compare/exchange unit
	bss_cmp u_cmp (
		.carry  (carry_q),
		.fetched(rdata),
		.res    (cmp_res)
	);

	assign in_xfer    = in_valid && in_ready;
	assign count_inc  = count_q + CW'(1);
	assign n_minus1   = count_q - CW'(1);
	assign n_minus2   = count_q - CW'(2);
	assign idx_at_end = (CW'(idx_q) == n_minus1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bss_pkg::S_COLLECT;
			count_q <= '0;
			idx_q   <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			pass_q  <= pass_d;
		end
	end

	// carried element, no reset needed
	always_ff @(posedge clk) begin
		carry_q <= carry_d;
	end

	// sequencer: next state, counters and buffer access
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pass_d   = pass_q;
		carry_d  = carry_q;
		in_ready = 1'b0;
		we       = 1'b0;
		waddr    = idx_q;
		wdata    = carry_q;
		raddr    = idx_q;
		out_load = 1'b0;
		case (state_q)
			bss_pkg::S_COLLECT: begin
				in_ready = 1'b1;
				waddr    = count_q[AW-1:0];
				wdata    = in_data.value;
				we       = in_xfer;
				if (in_xfer) begin
					count_d = count_inc;
					if (in_data.last_item || count_inc == CW'(MAX_COUNT)) begin
						idx_d  = '0;
						pass_d = '0;
						if (count_q == '0) begin
							state_d = bss_pkg::S_OUT_RD;
						end else begin
							state_d = bss_pkg::S_LOAD;
						end
					end
				end
			end
			bss_pkg::S_LOAD: begin
				raddr   = '0;
				state_d = bss_pkg::S_FIRST;
			end
			bss_pkg::S_FIRST: begin
				carry_d = rdata;
				idx_d   = AW'(1);
				state_d = bss_pkg::S_READ;
			end
			bss_pkg::S_READ: begin
				raddr   = idx_q;
				state_d = bss_pkg::S_CMP;
			end
			bss_pkg::S_CMP: begin
				// smaller value drops one place left, larger travels on
				we      = 1'b1;
				waddr   = idx_q - AW'(1);
				wdata   = cmp_res.lo;
				carry_d = cmp_res.hi;
				if (idx_at_end) begin
					state_d = bss_pkg::S_TAIL;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = bss_pkg::S_READ;
				end
			end
			bss_pkg::S_TAIL: begin
				// largest of this pass lands in the last slot
				we    = 1'b1;
				waddr = n_minus1[AW-1:0];
				wdata = carry_q;
				idx_d = '0;
				if (CW'(pass_q) == n_minus2) begin
					state_d = bss_pkg::S_OUT_RD;
				end else begin
					pass_d  = pass_q + AW'(1);
					state_d = bss_pkg::S_LOAD;
				end
			end
			bss_pkg::S_OUT_RD: begin
				raddr   = idx_q;
				state_d = bss_pkg::S_OUT_LD;
			end
			bss_pkg::S_OUT_LD: begin
				// hold the read address until the output register frees up
				raddr = idx_q;
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					if (idx_at_end) begin
						count_d = '0;
						idx_d   = '0;
						state_d = bss_pkg::S_COLLECT;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = bss_pkg::S_OUT_RD;
					end
				end
			end
			default: begin
				state_d = bss_pkg::S_COLLECT;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sorted_value <= rdata;
			out_q.last_result  <= idx_at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// set size never exceeds the buffer
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_COUNT))
		else $error("element count above capacity");

	// compare step always writes a slot left of the fetched one
	a_cmp_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bss_pkg::S_CMP |-> idx_q != '0)
		else $error("compare step at index zero");

	// a last-marked transfer closes the set
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_item |=> !in_ready)
		else $error("set not closed after last item");
`endif

endmodule

### hdl/bss_ram.sv
module bss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/bss_cmp.sv
module bss_cmp (
	input  logic [bss_pkg::DATA_W-1:0] carry,
	input  logic [bss_pkg::DATA_W-1:0] fetched,
	output bss_pkg::cmp_res_t          res
);

	// signed compare; the larger value keeps moving right
	always_comb begin
		res.swap = $signed(carry) > $signed(fetched);
		res.lo   = res.swap ? fetched : carry;
		res.hi   = res.swap ? carry : fetched;
	end

endmodule
